// ===== hdl/wheel_soft_start_stall_restart_core_macros.svh =====
// Assertion macros for the wheel soft start core.
// Included by the top level; relies on clk and arst_n being in scope.
`ifndef WHEEL_SOFT_START_STALL_RESTART_CORE_MACROS_SVH
`define WHEEL_SOFT_START_STALL_RESTART_CORE_MACROS_SVH

// same-cycle implication
`define WSSR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WSSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/wssr_pkg.sv =====
// Package for the wheel soft start core: register indexes, constants,
// configuration and state records. No dependencies.
package wssr_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 10;

	localparam logic [9:0] PWM_TOP       = 10'd800;
	localparam logic [9:0] LOCKOUT_MAX   = 10'd1023;
	localparam logic [7:0] STEP_TIMER_RST = 8'd30;

	localparam logic [5:0] RAMP_STEP_RST  = 6'd5;
	localparam logic [7:0] STEP_DELAY_RST = 8'd30;
	localparam logic [9:0] LOCKOUT_RST    = 10'd750;
	localparam logic [5:0] REACH_BAND_RST = 6'd5;
	localparam logic [5:0] DEAD_SPEED_RST = 6'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RAMP_STEP       = 3'd0,
		REG_STEP_DELAY      = 3'd1,
		REG_RESTART_LOCKOUT = 3'd2,
		REG_REACH_BAND      = 3'd3,
		REG_DEAD_SPEED      = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [5:0] ramp_step;
		logic [7:0] step_delay;
		logic [9:0] restart_lockout;
		logic [5:0] reach_band;
		logic [5:0] dead_speed;
	} cfg_t;

	typedef struct packed {
		logic [9:0] ramp_command;
		logic [7:0] step_timer;
		logic       start_flag;
		logic       speed_up_flag;
		logic       slow_down_flag;
		logic       reached_flag;
		logic       stall_flag;
		logic [9:0] lockout_timer;
		logic       prev_enable;
	} wheel_state_t;

endpackage

// ===== hdl/wssr_cfg.sv =====
// Configuration register file of the wheel soft start core.
// Depends on wssr_pkg.
module wssr_cfg import wssr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_step       <= RAMP_STEP_RST;
			cfg_q.step_delay      <= STEP_DELAY_RST;
			cfg_q.restart_lockout <= LOCKOUT_RST;
			cfg_q.reach_band      <= REACH_BAND_RST;
			cfg_q.dead_speed      <= DEAD_SPEED_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_RAMP_STEP:       cfg_q.ramp_step       <= wr_data[5:0];
				REG_STEP_DELAY:      cfg_q.step_delay      <= wr_data[7:0];
				REG_RESTART_LOCKOUT: cfg_q.restart_lockout <= wr_data[9:0];
				REG_REACH_BAND:      cfg_q.reach_band      <= wr_data[5:0];
				REG_DEAD_SPEED:      cfg_q.dead_speed      <= wr_data[5:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/wssr_tick.sv =====
// Next-state logic for one control tick: ramp, lockout, reach and stall.
// Depends on wssr_pkg.
module wssr_tick import wssr_pkg::*; (
	input  cfg_t         cfg,
	input  wheel_state_t cur,
	input  logic         wheel_enable,
	input  logic [9:0]   target_speed,
	input  logic [9:0]   measured_speed,
	output wheel_state_t nxt
);

	always_comb begin
		wheel_state_t s;
		logic [9:0]   tgt;
		logic         up;
		s   = cur;
		tgt = (target_speed > PWM_TOP) ? PWM_TOP : target_speed;
		up  = 1'b0;

		if (!wheel_enable) begin
			s.ramp_command   = '0;
			s.start_flag     = 1'b0;
			s.speed_up_flag  = 1'b0;
			s.slow_down_flag = 1'b0;
			s.stall_flag     = 1'b0;
			s.lockout_timer  = '0;
		end else begin
			if (!cur.prev_enable) s.start_flag = 1'b1;
			if (s.ramp_command < tgt) s.speed_up_flag = 1'b1;
			if (s.ramp_command > tgt) s.slow_down_flag = 1'b1;

			if ((s.start_flag || s.speed_up_flag || s.slow_down_flag) && s.step_timer != '0)
				s.step_timer = s.step_timer - 8'd1;

			if (s.stall_flag) begin
				if (s.lockout_timer != LOCKOUT_MAX) s.lockout_timer = s.lockout_timer + 10'd1;
				if (s.lockout_timer < cfg.restart_lockout) begin
					s.ramp_command = '0;
				end else begin
					s.speed_up_flag = 1'b1;
					s.stall_flag    = 1'b0;
				end
				if ({measured_speed, 1'b0} > {1'b0, tgt}) s.stall_flag = 1'b0;
			end

			if (!s.stall_flag && s.step_timer == '0) begin
				up = s.start_flag || s.speed_up_flag;
				if (up && s.ramp_command < tgt) begin
					if ((tgt - s.ramp_command) < {4'b0, cfg.ramp_step})
						s.ramp_command = tgt;
					else
						s.ramp_command = s.ramp_command + {4'b0, cfg.ramp_step};
					s.step_timer = cfg.step_delay;
				end else if (s.slow_down_flag && s.ramp_command > tgt) begin
					if ((s.ramp_command - tgt) < {4'b0, cfg.ramp_step})
						s.ramp_command = tgt;
					else
						s.ramp_command = s.ramp_command - {4'b0, cfg.ramp_step};
					s.step_timer = cfg.step_delay;
				end else if (up) begin
					s.start_flag    = 1'b0;
					s.speed_up_flag = 1'b0;
				end else if (s.slow_down_flag) begin
					s.slow_down_flag = 1'b0;
				end
			end
		end

		if ((11'(measured_speed) + 11'(cfg.reach_band)) > 11'(tgt) &&
		    11'(measured_speed) < (11'(tgt) + 11'(cfg.reach_band)))
			s.reached_flag = 1'b1;

		if (wheel_enable && s.reached_flag && measured_speed < 10'(cfg.dead_speed) &&
		    !s.speed_up_flag && !s.stall_flag) begin
			s.stall_flag    = 1'b1;
			s.lockout_timer = '0;
		end

		s.prev_enable = wheel_enable;
		nxt = s;
	end

endmodule

// ===== hdl/wheel_soft_start_stall_restart_core.sv =====
// Channel   | handshake                  | payload
// tick      | tick_valid / tick_stall    | wheel_enable, target_speed, measured_speed
// result    | result_valid / result_stall| pwm_compare, command_speed, target_reached, restarting
// cfg       | cfg_valid / cfg_ready      | cfg_index, cfg_data
// One item per cycle sustained while the result is not stalled; an accepted item goes
// through the input register, then the state update into the result register.
// Reset puts the wheel state to its reset values and loads the register defaults; no clearing pass.
// A stalled result holds the pipeline; the input register then raises tick_stall.
// Top level of the wheel soft start core; depends on wssr_pkg, wssr_cfg, wssr_tick
// and the macros header.
`include "wheel_soft_start_stall_restart_core_macros.svh"

module wheel_soft_start_stall_restart_core import wssr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  tick_valid,
	output logic                  tick_stall,
	input  logic                  wheel_enable,
	input  logic [9:0]            target_speed,
	input  logic [9:0]            measured_speed,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [9:0]            pwm_compare,
	output logic [9:0]            command_speed,
	output logic                  target_reached,
	output logic                  restarting,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t         cfg;
	wheel_state_t state_q;
	wheel_state_t state_nxt;

	logic       valid_s1;
	logic       en_s1;
	logic [9:0] tgt_s1;
	logic [9:0] meas_s1;

	logic       valid_s2;
	logic [9:0] pwm_s2;
	logic [9:0] cmd_s2;
	logic       reached_s2;
	logic       stall_s2;

	logic advance;
	logic take;

	assign cfg_ready = 1'b1;

	wssr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	wssr_tick u_tick (
		.cfg            (cfg),
		.cur            (state_q),
		.wheel_enable   (en_s1),
		.target_speed   (tgt_s1),
		.measured_speed (meas_s1),
		.nxt            (state_nxt)
	);

	assign advance    = !valid_s2 || !result_stall;
	assign tick_stall = valid_s1 && !advance;
	assign take       = tick_valid && !tick_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			en_s1   <= wheel_enable;
			tgt_s1  <= target_speed;
			meas_s1 <= measured_speed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{
				ramp_command:   '0,
				step_timer:     STEP_TIMER_RST,
				start_flag:     1'b0,
				speed_up_flag:  1'b0,
				slow_down_flag: 1'b0,
				reached_flag:   1'b0,
				stall_flag:     1'b0,
				lockout_timer:  '0,
				prev_enable:    1'b0
			};
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			pwm_s2     <= PWM_TOP - state_nxt.ramp_command;
			cmd_s2     <= state_nxt.ramp_command;
			reached_s2 <= state_nxt.reached_flag;
			stall_s2   <= state_nxt.stall_flag;
		end
	end

	assign result_valid   = valid_s2;
	assign pwm_compare    = pwm_s2;
	assign command_speed  = cmd_s2;
	assign target_reached = reached_s2;
	assign restarting     = stall_s2;

	`WSSR_ASSERT_NOW(a_pwm_sum, valid_s2, (11'(pwm_s2) + 11'(cmd_s2)) == 11'(PWM_TOP), "pwm and command do not sum to top")
	`WSSR_ASSERT_NOW(a_cmd_range, valid_s2, cmd_s2 <= PWM_TOP, "command above top")
	`WSSR_ASSERT_NOW(a_stall_enabled, state_q.stall_flag, state_q.prev_enable, "stall pending while disabled")
	`WSSR_ASSERT_NEXT(a_reached_sticky, state_q.reached_flag, state_q.reached_flag, "reached flag dropped")
	`WSSR_ASSERT_NEXT(a_item_moves, valid_s1 && advance, valid_s2, "item lost between stages")

endmodule
